[rtl/matrix_row_operation_engine_macros.svh]
// Assertion macros for the matrix row operation engine.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef MATRIX_ROW_OPERATION_ENGINE_MACROS_SVH
`define MATRIX_ROW_OPERATION_ENGINE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MROE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define MROE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mroe_pkg.sv]
// Shared types and constants of the matrix row operation engine.
// No dependencies; imported by the engine, mroe_alu and the testbench.
package mroe_pkg;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(MAX_COLS + 1);
  localparam int DATA_W   = 32;

  localparam logic [2:0] REQ_WRITE = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_SCALE = 3'd2;
  localparam logic [2:0] REQ_ADD   = 3'd3;
  localparam logic [2:0] REQ_SWAP  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [2:0]               req_type;
    logic [2:0]               row_a;
    logic [2:0]               row_b;
    logic [2:0]               row_dest;
    logic [2:0]               col_index;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic mul;
  } alu_ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
  } alu_res_t;

endpackage

[rtl/matrix_row_operation_engine.sv]
// Matrix row operation engine: a small sequencer around one memory and one
// shared multiply/add/saturate unit. Depends on mroe_pkg, mroe_ram, mroe_alu.
//
// Usage: present a request on req with start high; it is taken at a clock
// edge where start is high and busy is low. Each request gives exactly one
// response on rsp, valid for the single cycle in which done is high.
// Configuration (row and column counts) is written on cfg_wr_en, cfg_addr,
// cfg_data while no request is in flight; there is no read-back.
// Entry write and any range error answer straight from the check state,
// entry read answers after a wait for the registered read data, and scale,
// add and swap first walk every column in use, one column after another.
// Each column of a row operation reads the memory, waits for the registered
// read data, runs through the two stages of the shared arithmetic unit
// (for swap, latches both entries instead) and writes back over the single
// write port. One request is in flight at a time; busy is high until done.
// Reset returns both counts to eight and idles the sequencer; matrix
// contents are undefined until written and are not cleared.
// The receiver cannot stall: done is a one-cycle strobe.
module matrix_row_operation_engine
  import mroe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  output logic       done,
  output rsp_t       rsp,
  input  logic       cfg_wr_en,
  input  logic       cfg_addr,
  input  logic [3:0] cfg_data
);

`include "matrix_row_operation_engine_macros.svh"

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_RWT  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_EX   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_WR   = 4'd6;
  localparam logic [3:0] S_SW1  = 4'd7;
  localparam logic [3:0] S_SW2  = 4'd8;

  logic [3:0]        state;
  logic [3:0]        rows_in_use;
  logic [3:0]        cols_in_use;
  req_t              req_r;
  logic [CNT_W-1:0]  col;
  logic [CNT_W-1:0]  ncols_r;
  logic              sat_acc;
  logic [DATA_W-1:0] hold0;
  logic [DATA_W-1:0] hold1;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr0;
  logic [ADDR_W-1:0] raddr1;
  logic [DATA_W-1:0] rdata0;
  logic [DATA_W-1:0] rdata1;

  alu_ctl_t          alu_ctl;
  alu_res_t          alu_res;

  logic [CNT_W-1:0]  ncols;
  logic              entry_ok;
  logic              add_ok;
  logic              swap_ok;
  logic              col_last;
  logic [ADDR_W-1:0] entry_addr;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [ADDR_W-1:0] addr_d;

  function automatic logic row_ok(logic [2:0] r, logic [3:0] n);
    return (32'(r) < 32'(n)) && (32'(r) < MAX_ROWS);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(int unsigned r, int unsigned c);
    return ADDR_W'(r * MAX_COLS + c);
  endfunction

  assign ncols    = (32'(cols_in_use) < MAX_COLS) ? CNT_W'(cols_in_use) : CNT_W'(MAX_COLS);
  assign entry_ok = row_ok(req_r.row_dest, rows_in_use)
                    && (32'(req_r.col_index) < 32'(cols_in_use))
                    && (32'(req_r.col_index) < MAX_COLS);
  assign add_ok   = row_ok(req_r.row_a, rows_in_use) && row_ok(req_r.row_b, rows_in_use)
                    && row_ok(req_r.row_dest, rows_in_use);
  assign swap_ok  = row_ok(req_r.row_a, rows_in_use) && row_ok(req_r.row_b, rows_in_use);
  assign col_last = (col + CNT_W'(1)) == ncols_r;

  assign entry_addr = addr_of(32'(req_r.row_dest), 32'(req_r.col_index));
  assign addr_a     = addr_of(32'(req_r.row_a), 32'(col));
  assign addr_b     = addr_of(32'(req_r.row_b), 32'(col));
  assign addr_d     = addr_of(32'(req_r.row_dest), 32'(col));

  assign busy = state != S_IDLE;

  always_comb begin
    we    = 1'b0;
    waddr = addr_d;
    wdata = alu_res.value;
    case (state)
      S_CHK: begin
        we    = (req_r.req_type == REQ_WRITE) && entry_ok;
        waddr = entry_addr;
        wdata = req_r.value;
      end
      S_WR: begin
        we = 1'b1;
      end
      S_SW1: begin
        we    = 1'b1;
        waddr = addr_a;
        wdata = hold1;
      end
      S_SW2: begin
        we    = 1'b1;
        waddr = addr_b;
        wdata = hold0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign raddr0 = (state == S_CHK) ? entry_addr
                : (req_r.req_type == REQ_SCALE) ? addr_d : addr_a;
  assign raddr1 = addr_b;

  assign alu_ctl.load = (state == S_EX) && (req_r.req_type != REQ_SWAP);
  assign alu_ctl.mul  = req_r.req_type == REQ_SCALE;

  mroe_ram #(
    .DEPTH(DEPTH),
    .WIDTH(DATA_W),
    .AW   (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr0(raddr0),
    .raddr1(raddr1),
    .rdata0(rdata0),
    .rdata1(rdata1)
  );

  mroe_alu u_alu (
    .clk(clk),
    .ctl(alu_ctl),
    .a  (signed'(rdata0)),
    .b  ((req_r.req_type == REQ_SCALE) ? req_r.value : signed'(rdata1)),
    .res(alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 4'd8;
      cols_in_use <= 4'd8;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_ROWS: rows_in_use <= cfg_data;
        CFG_COLS: cols_in_use <= cfg_data;
        default:  rows_in_use <= rows_in_use;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      col     <= '0;
      sat_acc <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_r <= req;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          col     <= '0;
          ncols_r <= ncols;
          sat_acc <= 1'b0;
          rsp.read_value <= '0;
          rsp.status     <= ST_OK;
          state          <= S_IDLE;
          done           <= 1'b1;
          case (req_r.req_type)
            REQ_WRITE: begin
              if (!entry_ok) rsp.status <= ST_RANGE;
            end
            REQ_READ: begin
              if (!entry_ok) begin
                rsp.status <= ST_RANGE;
              end else begin
                state <= S_RWT;
                done  <= 1'b0;
              end
            end
            REQ_SCALE: begin
              if (!row_ok(req_r.row_dest, rows_in_use)) begin
                rsp.status <= ST_RANGE;
              end else if (ncols != '0) begin
                state <= S_RD;
                done  <= 1'b0;
              end
            end
            REQ_ADD: begin
              if (!add_ok) begin
                rsp.status <= ST_RANGE;
              end else if (ncols != '0) begin
                state <= S_RD;
                done  <= 1'b0;
              end
            end
            REQ_SWAP: begin
              if (!swap_ok) begin
                rsp.status <= ST_RANGE;
              end else if (ncols != '0) begin
                state <= S_RD;
                done  <= 1'b0;
              end
            end
            default: begin
              rsp.status <= ST_RANGE;
            end
          endcase
        end
        S_RWT: begin
          rsp.read_value <= signed'(rdata0);
          done           <= 1'b1;
          state          <= S_IDLE;
        end
        S_RD: begin
          state <= S_EX;
        end
        S_EX: begin
          hold0 <= rdata0;
          hold1 <= rdata1;
          state <= (req_r.req_type == REQ_SWAP) ? S_SW1 : S_M2;
        end
        S_M2: begin
          state <= S_WR;
        end
        S_SW1: begin
          state <= S_SW2;
        end
        S_WR, S_SW2: begin
          if (col_last) begin
            rsp.status <= (sat_acc || ((state == S_WR) && alu_res.sat)) ? ST_SAT : ST_OK;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            col   <= col + CNT_W'(1);
            state <= S_RD;
          end
          if (state == S_WR) sat_acc <= sat_acc || alu_res.sat;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MROE_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while sequencer busy")
  `MROE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not start")
  `MROE_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `MROE_ASSERT_NOW(a_status_code, done,
    (rsp.status == ST_OK) || (rsp.status == ST_RANGE) || (rsp.status == ST_SAT),
    "undefined status code")

endmodule

[rtl/mroe_ram.sv]
// Generic memory: one write port, two registered read ports.
// No dependencies.
module mroe_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

[rtl/mroe_alu.sv]
// Shared two-stage arithmetic unit: Q16.16 multiply with rounding, or add,
// followed by saturation to 32 bits. Depends on mroe_pkg.
module mroe_alu
  import mroe_pkg::*;
(
  input  logic                     clk,
  input  alu_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output alu_res_t                 res
);

  logic signed [63:0] prod;
  logic signed [63:0] sum;
  logic signed [63:0] p;
  logic               p_mul;
  logic signed [63:0] v;
  logic [32:0]        hi;
  logic               sat;

  assign prod = a * b;
  assign sum  = 64'(a) + 64'(b);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      p     <= ctl.mul ? prod : sum;
      p_mul <= ctl.mul;
    end
  end

  assign v   = p_mul ? ((p + 64'sd32768) >>> 16) : p;
  assign hi  = v[63:31];
  assign sat = !((&hi) || (~|hi));

  always_ff @(posedge clk) begin
    res.sat   <= sat;
    res.value <= sat ? (v[63] ? Q_MIN : Q_MAX) : v[DATA_W-1:0];
  end

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for matrix_row_operation_engine: directed and random
// requests checked against a built-in predictor of the matrix and its row operations.
// Depends on mroe_pkg and the engine RTL; reads no files.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mroe_pkg::*;

  localparam int REQ_W         = $bits(req_t);
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int SETTLE_CYCLES = 40;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  logic       busy;
  req_t       req_drv   = '0;
  logic       done;
  rsp_t       rsp_out;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_addr  = CFG_ROWS;
  logic [3:0] cfg_data  = '0;

  req_t              req_backlog[$];
  rsp_t              rsp_due_q[$];
  logic [DATA_W-1:0] shadow_mat [DEPTH];
  bit                written [DEPTH];
  logic [3:0]        rows_cfg    = 4'(MAX_ROWS);
  logic [3:0]        cols_cfg    = 4'(MAX_COLS);
  int                errors      = 0;
  int                cycle_count = 0;
  int                gap_left    = 0;
  bit                taken       = 1'b0;
  bit                drain_hold  = 1'b0;
  bit                calm        = 1'b0;

  matrix_row_operation_engine dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req_drv),
    .done      (done),
    .rsp       (rsp_out),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  function automatic int eff_count(logic [3:0] n, int lim);
    return (n > lim) ? lim : int'(n);
  endfunction

  function automatic logic [DATA_W-1:0] clip_q(longint v, inout bit sat);
    if (v > longint'($signed(Q_MAX))) begin
      sat = 1'b1;
      return Q_MAX;
    end
    if (v < longint'($signed(Q_MIN))) begin
      sat = 1'b1;
      return Q_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  task automatic apply_row_request(input req_t r, output rsp_t res);
    int                nr;
    int                nc;
    int                src_a;
    int                src_b;
    int                dst;
    bit                sat;
    longint            a;
    longint            b;
    logic [DATA_W-1:0] t;
    nr    = eff_count(rows_cfg, MAX_ROWS);
    nc    = eff_count(cols_cfg, MAX_COLS);
    src_a = r.row_a * MAX_COLS;
    src_b = r.row_b * MAX_COLS;
    dst   = r.row_dest * MAX_COLS;
    res   = '0;
    sat   = 1'b0;
    case (r.req_type)
      REQ_WRITE, REQ_READ: begin
        if (r.row_dest >= nr || r.col_index >= nc) res.status = ST_RANGE;
        else if (r.req_type == REQ_WRITE) shadow_mat[dst + r.col_index] = r.value;
        else res.read_value = shadow_mat[dst + r.col_index];
      end
      REQ_SCALE: begin
        if (r.row_dest >= nr) begin
          res.status = ST_RANGE;
        end else begin
          b = $signed(r.value);
          for (int c = 0; c < nc; c++) begin
            a = $signed(shadow_mat[dst + c]);
            shadow_mat[dst + c] = clip_q((a * b + 32768) >>> 16, sat);
          end
          res.status = sat ? ST_SAT : ST_OK;
        end
      end
      REQ_ADD: begin
        if (r.row_a >= nr || r.row_b >= nr || r.row_dest >= nr) begin
          res.status = ST_RANGE;
        end else begin
          for (int c = 0; c < nc; c++) begin
            a = $signed(shadow_mat[src_a + c]);
            b = $signed(shadow_mat[src_b + c]);
            shadow_mat[dst + c] = clip_q(a + b, sat);
          end
          res.status = sat ? ST_SAT : ST_OK;
        end
      end
      REQ_SWAP: begin
        if (r.row_a >= nr || r.row_b >= nr) begin
          res.status = ST_RANGE;
        end else begin
          for (int c = 0; c < nc; c++) begin
            t = shadow_mat[src_a + c];
            shadow_mat[src_a + c] = shadow_mat[src_b + c];
            shadow_mat[src_b + c] = t;
          end
        end
      end
      default: res.status = ST_RANGE;
    endcase
  endtask

  // Find an entry the request would read before it was ever written.
  function automatic bit first_unwritten(input req_t r, output int hole);
    int                  nr;
    int                  nc;
    logic [MAX_ROWS-1:0] reads_row;
    nr        = eff_count(rows_cfg, MAX_ROWS);
    nc        = eff_count(cols_cfg, MAX_COLS);
    hole      = 0;
    reads_row = '0;
    case (r.req_type)
      REQ_READ: begin
        if (r.row_dest < nr && r.col_index < nc) begin
          hole = r.row_dest * MAX_COLS + r.col_index;
          return !written[hole];
        end
      end
      REQ_SCALE: begin
        if (r.row_dest < nr) reads_row[r.row_dest] = 1'b1;
      end
      REQ_ADD: begin
        if (r.row_a < nr && r.row_b < nr && r.row_dest < nr) begin
          reads_row[r.row_a] = 1'b1;
          reads_row[r.row_b] = 1'b1;
        end
      end
      REQ_SWAP: begin
        if (r.row_a < nr && r.row_b < nr) begin
          reads_row[r.row_a] = 1'b1;
          reads_row[r.row_b] = 1'b1;
        end
      end
      default: ;
    endcase
    for (int row = 0; row < MAX_ROWS; row++)
      for (int c = 0; c < nc; c++)
        if (reads_row[row] && !written[row * MAX_COLS + c]) begin
          hole = row * MAX_COLS + c;
          return 1'b1;
        end
    return 1'b0;
  endfunction

  function automatic logic [DATA_W-1:0] random_q16();
    case ($urandom_range(0, 5))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return $urandom();
      3:       return 32'($urandom_range(0, 32'h2_0000)) - 32'h1_0000;
      default: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   nr;
    int   nc;
    int   hole;
    nr = eff_count(rows_cfg, MAX_ROWS);
    nc = eff_count(cols_cfg, MAX_COLS);
    if (nr == 0 || nc == 0 || $urandom_range(0, 9) == 0) begin
      do r = REQ_W'({$urandom(), $urandom()});
      while (first_unwritten(r, hole));
      return r;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: r.req_type = REQ_WRITE;
      3, 4:    r.req_type = REQ_READ;
      5:       r.req_type = REQ_SCALE;
      6, 7:    r.req_type = REQ_ADD;
      default: r.req_type = REQ_SWAP;
    endcase
    r.row_a     = 3'($urandom_range(0, nr - 1));
    r.row_b     = 3'($urandom_range(0, nr - 1));
    r.row_dest  = 3'($urandom_range(0, nr - 1));
    r.col_index = 3'($urandom_range(0, nc - 1));
    r.value     = random_q16();
    if (first_unwritten(r, hole)) begin
      r.req_type  = REQ_WRITE;
      r.row_dest  = 3'(hole / MAX_COLS);
      r.col_index = 3'(hole % MAX_COLS);
    end
    return r;
  endfunction

  function automatic void enqueue_request(req_t r);
    int nr;
    int nc;
    int dst;
    nr  = eff_count(rows_cfg, MAX_ROWS);
    nc  = eff_count(cols_cfg, MAX_COLS);
    dst = r.row_dest * MAX_COLS;
    if (r.req_type == REQ_WRITE && r.row_dest < nr && r.col_index < nc)
      written[dst + r.col_index] = 1'b1;
    if (r.req_type == REQ_ADD && r.row_a < nr && r.row_b < nr && r.row_dest < nr)
      for (int c = 0; c < nc; c++) written[dst + c] = 1'b1;
    req_backlog.push_back(r);
  endfunction

  function automatic void directed(logic [2:0] op, int ra, int rb, int rd, int ci,
                                   logic [DATA_W-1:0] val);
    req_t r;
    r.req_type  = op;
    r.row_a     = 3'(ra);
    r.row_b     = 3'(rb);
    r.row_dest  = 3'(rd);
    r.col_index = 3'(ci);
    r.value     = val;
    enqueue_request(r);
  endfunction

  task automatic random_phase(int count);
    repeat (count) enqueue_request(random_request());
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || start || rsp_due_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_shape(logic [3:0] rows, logic [3:0] cols);
    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_ROWS;
    cfg_data  <= rows;
    @(negedge clk);
    cfg_addr  <= CFG_COLS;
    cfg_data  <= cols;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  always @(negedge clk) begin : drive
    logic nxt_start;
    req_t nxt_req;
    nxt_start = start;
    nxt_req   = req_drv;
    if (start && taken) nxt_start = 1'b0;
    taken = 1'b0;
    if (!rst && !nxt_start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_backlog.size() > 0 && !(drain_hold && rsp_due_q.size() > 0)) begin
        drain_hold = 1'b0;
        nxt_req    = req_backlog.pop_front();
        nxt_start  = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 7);
        if (!calm && $urandom_range(0, 149) == 0) drain_hold = 1'b1;
      end
    end
    start   <= nxt_start;
    req_drv <= nxt_req;
  end

  always @(posedge clk) begin : observe
    rsp_t want;
    if (rst) begin
      rows_cfg = 4'(MAX_ROWS);
      cols_cfg = 4'(MAX_COLS);
    end else begin
      if (cfg_wr_en) begin
        if (cfg_addr == CFG_ROWS) rows_cfg = cfg_data;
        else cols_cfg = cfg_data;
      end
      if (done) begin
        if (rsp_due_q.size() == 0) begin
          errors++;
          $display("%0t: result with none due: read_value %h status %0d",
                   $time, rsp_out.read_value, rsp_out.status);
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp_out.read_value !== want.read_value) begin
            errors++;
            $display("%0t: read_value expected %h actual %h",
                     $time, want.read_value, rsp_out.read_value);
          end
          if (rsp_out.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, rsp_out.status);
          end
        end
      end
      if (start && !busy) begin
        apply_row_request(req_drv, want);
        rsp_due_q.push_back(want);
        taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_shape(4'd2, 4'd2);
    directed(REQ_WRITE, 0, 0, 0, 0, Q_MAX);
    directed(REQ_WRITE, 0, 0, 0, 1, Q_MIN);
    directed(REQ_WRITE, 0, 0, 1, 0, 32'h0000_0001);
    directed(REQ_WRITE, 0, 0, 1, 1, 32'hffff_ffff);
    directed(REQ_READ,  0, 0, 0, 0, '0);
    directed(REQ_READ,  0, 0, 0, 1, '0);
    directed(REQ_SCALE, 0, 0, 1, 0, 32'h0000_8000);
    directed(REQ_READ,  0, 0, 1, 0, '0);
    directed(REQ_READ,  0, 0, 1, 1, '0);
    directed(REQ_WRITE, 0, 0, 1, 1, 32'h0001_8000);
    directed(REQ_SCALE, 0, 0, 0, 0, 32'h0001_0000);
    directed(REQ_SCALE, 0, 0, 0, 0, 32'h0002_0000);
    directed(REQ_ADD,   0, 1, 0, 0, '0);
    directed(REQ_ADD,   1, 1, 1, 0, '0);
    directed(REQ_SWAP,  0, 1, 0, 0, '0);
    directed(REQ_SWAP,  1, 1, 0, 0, '0);
    directed(REQ_READ,  0, 0, 0, 1, '0);
    directed(REQ_SCALE, 0, 0, 0, 0, Q_MIN);
    directed(REQ_WRITE, 0, 0, 2, 0, Q_MAX);
    directed(REQ_READ,  0, 0, 0, 2, '0);
    directed(REQ_SCALE, 0, 0, 7, 0, 32'h0001_0000);
    directed(REQ_ADD,   0, 5, 1, 0, '0);
    directed(REQ_SWAP,  3, 0, 0, 0, '0);
    directed(REQ_SWAP + 3'd1, 0, 0, 0, 0, '0);
    directed(REQ_SWAP + 3'd2, 0, 0, 0, 0, '0);
    directed(REQ_SWAP + 3'd3, 0, 0, 0, 0, '0);
    directed(REQ_READ,  0, 0, 1, 1, '0);

    set_shape(4'd8, 4'd8);
    random_phase(200);
    set_shape(4'd1, 4'd1);
    random_phase(60);
    set_shape(4'd3, 4'd5);
    random_phase(120);
    set_shape(4'd0, 4'd0);
    random_phase(30);
    set_shape(4'd15, 4'd15);
    random_phase(150);
    set_shape(4'd8, 4'd1);
    random_phase(80);
    set_shape(4'd1, 4'd8);
    random_phase(80);
    set_shape(4'd5, 4'd3);
    random_phase(100);
    calm = 1'b1;
    set_shape(4'd8, 4'd8);
    random_phase(180);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[matrix_row_operation_engine.f]
+incdir+rtl
rtl/mroe_pkg.sv
rtl/mroe_ram.sv
rtl/mroe_alu.sv
rtl/matrix_row_operation_engine.sv
tb/sv/tb_top.sv
